/* design/mexp_pkg.sv */
// shared types and constants for the modular exponentiation block
// no dependencies; used by mexp_mulmod and modular_exponentiation
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

    localparam int DATA_BITS = 32;
    localparam int CNT_BITS  = $clog2(DATA_BITS);

    typedef logic [DATA_BITS-1:0] word_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    // configuration register indexes
    localparam logic REG_EXPONENT = 1'b0;
    localparam logic REG_MODULUS  = 1'b1;

    // request to the modular multiplier
    typedef struct packed {
        logic  start;
        word_t a;   // multiplicand, at most modulus + 1
        word_t b;   // multiplier, scanned msb first
        word_t m;   // modulus, zero means wrap at DATA_BITS
    } mm_req_t;

    // answer from the modular multiplier
    typedef struct packed {
        logic  busy;
        logic  done;
        word_t result;
    } mm_rsp_t;

endpackage

`default_nettype wire

/* design/mexp_mulmod.sv */
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
// depends on mexp_pkg
`timescale 1ns / 1ps
`default_nettype none

module mexp_mulmod
    import mexp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire mm_req_t req,
    output mm_rsp_t      rsp
);

    localparam int T_BITS = DATA_BITS + 2;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    cnt_t                cnt_reg, cnt_next;
    word_t               acc_reg, acc_next;
    word_t               a_reg, a_next;
    word_t               b_reg, b_next;
    word_t               m_reg, m_next;

    logic [T_BITS-1:0]   t;
    logic [T_BITS-1:0]   m1;
    logic [T_BITS-1:0]   m2;
    logic [T_BITS-1:0]   d1;
    logic [T_BITS-1:0]   d2;
    word_t               step;

    // acc stays below m, so 2*acc + a < 3m and at most two subtractions fit
    always_comb
    begin
        t    = {1'b0, acc_reg, 1'b0}
             + (b_reg[DATA_BITS-1] ? {2'b00, a_reg} : {T_BITS{1'b0}});
        m1   = {2'b00, m_reg};
        m2   = {1'b0, m_reg, 1'b0};
        d1   = t - m1;
        d2   = t - m2;
        if (m_reg == '0)
            step = t[DATA_BITS-1:0];
        else if (t >= m2)
            step = d2[DATA_BITS-1:0];
        else if (t >= m1)
            step = d1[DATA_BITS-1:0];
        else
            step = t[DATA_BITS-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        if (busy_reg)
        begin
            acc_next = step;
            b_next   = {b_reg[DATA_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = cnt_t'(DATA_BITS - 1);
            acc_next  = '0;
            a_next    = req.a;
            b_next    = req.b;
            m_next    = req.m;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
    end

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

`default_nettype wire

/* design/modular_exponentiation.sv */
// Raises each accepted message word to the configured exponent modulo the configured
// modulus by left-to-right square-and-multiply. All arithmetic runs on one shared
// bit-serial modular multiplier that retires one multiplier bit per cycle. A word first
// goes through one modular product to reduce it modulo the modulus, then each of the
// DATA_BITS exponent bits takes a square and, where the bit is set, a multiply. An
// exponent of zero or one returns the word unchanged. A modulus of zero wraps at
// DATA_BITS. One word is in flight at a time; the result word sits in an output
// register while the next word is accepted.
// depends on mexp_pkg and mexp_mulmod
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation
    import mexp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  wire logic  wr_index,
    input  wire word_t wr_data,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire word_t message_word,
    output logic       out_valid,
    input  wire logic  out_stall,
    output word_t      result_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BASE,
        S_SQR,
        S_MUL,
        S_FINISH
    } state_t;

    state_t  state_reg, state_next;
    word_t   exponent_reg;
    word_t   modulus_reg;
    word_t   base_reg, base_next;
    word_t   acc_reg, acc_next;
    cnt_t    bit_reg, bit_next;
    logic    out_valid_reg, out_valid_next;
    word_t   result_reg, result_next;

    mm_req_t mm_req;
    mm_rsp_t mm_rsp;
    logic    in_accept;
    logic    exp_trivial;
    word_t   acc_init;

    mexp_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req),
        .rsp   (mm_rsp)
    );

    assign in_accept   = in_valid && !in_stall;
    assign exp_trivial = (exponent_reg[DATA_BITS-1:1] == '0);
    assign acc_init    = (modulus_reg == word_t'(1)) ? '0 : word_t'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= word_t'(1);
            modulus_reg  <= word_t'(1);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_EXPONENT: exponent_reg <= wr_data;
                REG_MODULUS:  modulus_reg  <= wr_data;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        mm_req.start   = 1'b0;
        mm_req.a       = acc_reg;
        mm_req.b       = acc_reg;
        mm_req.m       = modulus_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    bit_next = cnt_t'(DATA_BITS - 1);
                    if (exp_trivial)
                    begin
                        acc_next   = message_word;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        // reduce the word: 1 * word mod m
                        mm_req.start = 1'b1;
                        mm_req.a     = word_t'(1);
                        mm_req.b     = message_word;
                        state_next   = S_BASE;
                    end
                end
            end
            S_BASE:
            begin
                if (mm_rsp.done)
                begin
                    base_next    = mm_rsp.result;
                    acc_next     = acc_init;
                    mm_req.start = 1'b1;
                    mm_req.a     = acc_init;
                    mm_req.b     = acc_init;
                    state_next   = S_SQR;
                end
            end
            S_SQR:
            begin
                if (mm_rsp.done)
                begin
                    acc_next = mm_rsp.result;
                    if (exponent_reg[bit_reg])
                    begin
                        mm_req.start = 1'b1;
                        mm_req.a     = base_reg;
                        mm_req.b     = mm_rsp.result;
                        state_next   = S_MUL;
                    end
                    else if (bit_reg == '0)
                        state_next = S_FINISH;
                    else
                    begin
                        bit_next     = bit_reg - 1'b1;
                        mm_req.start = 1'b1;
                        mm_req.a     = mm_rsp.result;
                        mm_req.b     = mm_rsp.result;
                    end
                end
            end
            S_MUL:
            begin
                if (mm_rsp.done)
                begin
                    acc_next = mm_rsp.result;
                    if (bit_reg == '0)
                        state_next = S_FINISH;
                    else
                    begin
                        bit_next     = bit_reg - 1'b1;
                        mm_req.start = 1'b1;
                        mm_req.a     = mm_rsp.result;
                        mm_req.b     = mm_rsp.result;
                        state_next   = S_SQR;
                    end
                end
            end
            S_FINISH:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    result_next    = acc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            bit_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bit_reg       <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign result_word = result_reg;

`ifndef SYNTHESIS
    // the multiplier only reports a product while a word is being worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        mm_rsp.done |-> (state_reg == S_BASE || state_reg == S_SQR || state_reg == S_MUL))
        else $error("multiplier done outside a multiply state");

    // a new product is never requested while the multiplier is still running
    assert property (@(posedge clk) disable iff (!rst_n)
        mm_req.start |-> !mm_rsp.busy)
        else $error("multiplier started while busy");

    // a word is only presented after the sequencer has finished
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result word raised outside finish");

    // exponent zero or one skips the multiplier entirely
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && exp_trivial) |=> (state_reg == S_FINISH))
        else $error("trivial exponent did not bypass");
`endif

endmodule

`default_nettype wire

/* verif/testbench.sv */
// self-checking testbench for modular_exponentiation: random key settings and words,
// with the expected result of every accepted word worked out in a scoreboard class
// depends on mexp_pkg and the modular_exponentiation rtl
`timescale 1ns / 1ps

module testbench;
    import mexp_pkg::*;

    localparam int WATCHDOG_LIMIT = 30000;
    localparam int HOLD_CYCLES    = 6000;
    localparam int ITEM_TARGET    = 290;

    class exp_scoreboard;
        word_t exp_key;
        word_t mod_key;
        word_t expected_words[$];
        int    errors;

        function new();
            exp_key = 1;
            mod_key = 1;
            errors  = 0;
        endfunction

        function void set_key(logic index, word_t value);
            if (index == REG_EXPONENT)
                exp_key = value;
            else
                mod_key = value;
        endfunction

        // a zero modulus wraps at the word width instead of reducing
        function word_t mul_mod(word_t a, word_t b, word_t m);
            logic [63:0] prod;
            prod = {32'b0, a} * {32'b0, b};
            if (m == 0)
                return prod[DATA_BITS-1:0];
            return word_t'(prod % {32'b0, m});
        endfunction

        function word_t pow_mod(word_t base, word_t e, word_t m);
            word_t acc;
            word_t b;
            b   = (m == 0) ? base : base % m;
            acc = (m == 1) ? '0 : word_t'(1);
            for (int i = DATA_BITS - 1; i >= 0; i--)
            begin
                acc = mul_mod(acc, acc, m);
                if (e[i])
                    acc = mul_mod(acc, b, m);
            end
            return acc;
        endfunction

        function void note_word(word_t w);
            // exponent zero or one passes the word through unreduced
            if (exp_key <= 1)
                expected_words.push_back(w);
            else
                expected_words.push_back(pow_mod(w, exp_key, mod_key));
        endfunction

        function void check_result(word_t r);
            word_t want;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %h", $time, r);
                errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (r !== want)
                begin
                    $display("%0t: result_word mismatch, expected %h, actual %h",
                             $time, want, r);
                    errors++;
                end
            end
        endfunction
    endclass

    logic  clk          = 1'b0;
    logic  rst_n        = 1'b0;
    logic  wr_en        = 1'b0;
    logic  wr_index     = REG_EXPONENT;
    word_t wr_data      = '0;
    logic  in_valid     = 1'b0;
    logic  in_stall;
    word_t message_word = '0;
    logic  out_valid;
    logic  out_stall    = 1'b0;
    word_t result_word;

    exp_scoreboard sb;
    bit quiet        = 1'b0;
    bit hold_pending = 1'b0;
    int words_sent   = 0;
    int stuck_cycles = 0;

    modular_exponentiation i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .message_word (message_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_word  (result_word)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_word(message_word);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(result_word);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || wr_en || !rst_n)
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d words outstanding", $time,
                     sb.expected_words.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= !quiet && ($urandom_range(0, 99) < 15);
        end
    end

    // writes both key registers on consecutive edges while the block is idle
    task automatic configure(word_t e, word_t m);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= REG_EXPONENT;
        wr_data  <= e;
        @(posedge clk);
        sb.set_key(REG_EXPONENT, e);
        wr_index <= REG_MODULUS;
        wr_data  <= m;
        @(posedge clk);
        sb.set_key(REG_MODULUS, m);
        wr_en <= 1'b0;
    endtask

    task automatic send_word(word_t w);
        while (!quiet && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        message_word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_words(word_t words[$]);
        foreach (words[i])
            send_word(words[i]);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.expected_words.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        word_t e;
        word_t m;
        word_t w;
        word_t batch[$];
        int    phase;
        int    count;

        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset keys pass the word through
        send_words('{32'h0, 32'hFFFF_FFFF, 32'h1, 32'hA5C3_0F96});
        drain();

        // exponent zero returns the word unreduced
        configure(32'h0, 32'd17);
        send_words('{32'h0, 32'hFFFF_FFFF, 32'd5});
        drain();

        configure(32'd2, 32'hFFFF_FFFF);
        send_words('{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h1, 32'h1234_5678});
        drain();

        // widest exponent, every bit set
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFB);
        send_words('{32'h0, 32'd2, 32'hFFFF_FFFF});
        drain();

        // modulus one always gives zero
        configure(32'd3, 32'd1);
        send_words('{32'h0, 32'hFFFF_FFFF, 32'd7});
        drain();

        configure(32'd65537, 32'd3233);
        send_words('{32'd65, 32'hFFFF_FFFF});
        drain();

        phase = 0;
        while (words_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0:       e = 32'h0;
                1:       e = 32'h1;
                2:       e = 32'd2;
                3:       e = 32'hFFFF_FFFF;
                4:       e = 32'd65537;
                default: e = $urandom;
            endcase
            case ($urandom_range(0, 7))
                0:       m = 32'd1;
                1:       m = 32'hFFFF_FFFF;
                2:       m = 32'h1 << $urandom_range(1, 31);
                3:       m = $urandom_range(2, 1000);
                default: m = $urandom;
            endcase
            if (m == 0)
                m = 32'd1;
            configure(e, m);

            // phase 1 stalls the result side for a long time, phase 3 runs flat out
            quiet = (phase == 3);
            if (phase == 1)
                hold_pending = 1'b1;

            batch.delete();
            count = $urandom_range(8, 24);
            repeat (count)
            begin
                case ($urandom_range(0, 9))
                    0:       w = 32'h0;
                    1:       w = 32'hFFFF_FFFF;
                    2:       w = $urandom_range(0, 255);
                    3:       w = m - 1;
                    default: w = $urandom;
                endcase
                batch.push_back(w);
            end
            send_words(batch);
            drain();
            phase++;
        end

        quiet = 1'b0;
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.expected_words.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
